### rtl/art_pkg.sv
// Package for the allocation record table: sizes, codes and the queued item type.
// No dependencies.
`timescale 1ns / 1ps
package art_pkg;
  localparam int TABLE_ENTRIES = 4096;
  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = SLOT_W + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_RESIZE = 2'd2;
  localparam logic [1:0] MODE_REPORT = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NULL = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_KIND = 3'd4;

  localparam logic CFG_BREAK_SEQ = 1'b0;
  localparam logic CFG_BREAK_ADDR = 1'b1;

  localparam logic [12:0] COUNT_MAX = 13'h1FFF;
  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        null_addr;
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [31:0] bytes;
    logic [1:0]  kind;
  } cmd_t;
endpackage

### rtl/art_front.sv
// Front end: accepts items, flags null addresses, and queues commands.
// Depends on art_pkg.
`timescale 1ns / 1ps
module art_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_addr,
  input  logic [31:0]         in_bytes,
  input  logic [1:0]          in_kind,
  output logic                q_valid,
  input  logic                q_ready,
  output art_pkg::cmd_t       q_cmd
);
  art_pkg::cmd_t q_r [art_pkg::QUEUE_DEPTH];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  art_pkg::cmd_t cmd;

  always_comb begin
    cmd.null_addr = (in_mode != art_pkg::MODE_REPORT) && (in_addr == 32'd0);
    cmd.mode = in_mode;
    cmd.addr = in_addr;
    cmd.bytes = in_bytes;
    cmd.kind = in_kind;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = q_r[rp_r];
  assign wp_nxt = push ? ~wp_r : wp_r;
  assign rp_nxt = pop ? ~rp_r : rp_r;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= cmd;
  end
endmodule

### rtl/art_back.sv
// Back end: table memories, home-slot probe, scans, report walk, result register.
// Depends on art_pkg.
`timescale 1ns / 1ps
module art_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  art_pkg::cmd_t       q_cmd,
  input  logic [63:0]         break_seq,
  input  logic [31:0]         break_addr,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2:0]          out_status,
  output logic [11:0]         out_slot,
  output logic [63:0]         out_seq,
  output logic                out_brk,
  output logic [12:0]         out_count,
  output logic [47:0]         out_bytes
);
  localparam int SW = art_pkg::SLOT_W;
  localparam int CW = art_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_HOME = 7'b0000100,
    S_SCAN = 7'b0001000, S_LAST = 7'b0010000, S_DONE = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  logic        val_mem [art_pkg::TABLE_ENTRIES];
  logic [31:0] adr_mem [art_pkg::TABLE_ENTRIES];
  logic [31:0] byt_mem [art_pkg::TABLE_ENTRIES];
  logic [1:0]  knd_mem [art_pkg::TABLE_ENTRIES];

  state_t        st_r, st_nxt;
  art_pkg::cmd_t cmd_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] rd_addr, rslot_r;
  logic          rv_r;
  logic [31:0]   ra_r, rb_r;
  logic [1:0]    rk_r;
  logic [63:0]   ctr_r;
  logic [12:0]   cnt_r;
  logic [47:0]   sum_r;
  logic          found_r;
  logic [SW-1:0] fslot_r;
  logic [1:0]    fkind_r;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic          wr_val;
  logic          wr_payload, wr_bytes_only;
  logic          hit;
  logic [63:0]   seq_new;
  logic [48:0]   sum_add;

  assign hit = (cmd_r.mode == art_pkg::MODE_RECORD) ? !rv_r
             : (cmd_r.mode == art_pkg::MODE_REPORT) ? 1'b0 : (rv_r && ra_r == cmd_r.addr);
  assign seq_new = ctr_r + 64'd1;
  assign sum_add = {1'b0, sum_r} + {17'd0, rb_r};
  assign q_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    rd_addr = idx_r[SW-1:0];
    unique case (st_r)
      S_CLEAR: begin
        if (idx_r == CW'(art_pkg::TABLE_ENTRIES - 1)) st_nxt = S_IDLE;
        idx_nxt = idx_r + CW'(1);
      end
      S_IDLE: begin
        rd_addr = q_cmd.addr[SW-1:0];
        idx_nxt = '0;
        if (q_valid) st_nxt = q_cmd.null_addr ? S_DONE
                          : (q_cmd.mode == art_pkg::MODE_REPORT ? S_SCAN : S_HOME);
      end
      S_HOME: begin
        rd_addr = '0;
        idx_nxt = CW'(1);
        st_nxt = hit ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (found_r) st_nxt = S_DONE;
        else if (idx_r == CW'(art_pkg::TABLE_ENTRIES - 1)) st_nxt = S_LAST;
        else idx_nxt = idx_r + CW'(1);
      end
      S_LAST: st_nxt = S_DONE;
      S_DONE: st_nxt = S_OUT;
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // table writes
  always_comb begin
    wr_en = 1'b0;
    wr_addr = fslot_r;
    wr_val = 1'b1;
    wr_payload = 1'b0;
    wr_bytes_only = 1'b0;
    if (st_r == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = idx_r[SW-1:0];
      wr_val = 1'b0;
    end else if (st_r == S_DONE && !cmd_r.null_addr && found_r) begin
      unique case (cmd_r.mode)
        art_pkg::MODE_RECORD: begin wr_en = 1'b1; wr_payload = 1'b1; end
        art_pkg::MODE_RELEASE: begin wr_en = 1'b1; wr_val = 1'b0; end
        art_pkg::MODE_RESIZE: begin
          wr_en = 1'b1;
          wr_bytes_only = (fkind_r == cmd_r.kind);
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rv_r <= val_mem[rd_addr];
    ra_r <= adr_mem[rd_addr];
    rb_r <= byt_mem[rd_addr];
    rk_r <= knd_mem[rd_addr];
    rslot_r <= rd_addr;
    if (wr_en) val_mem[wr_addr] <= wr_val;
    if (wr_payload) begin
      adr_mem[wr_addr] <= cmd_r.addr;
      knd_mem[wr_addr] <= cmd_r.kind;
    end
    if (wr_payload || wr_bytes_only) byt_mem[wr_addr] <= cmd_r.bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      idx_r <= '0;
      ctr_r <= '0;
      out_tvalid <= 1'b0;
      found_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          cmd_r <= q_cmd;
          found_r <= 1'b0;
          cnt_r <= '0;
          sum_r <= '0;
        end
        S_HOME: if (hit) begin
          found_r <= 1'b1;
          fslot_r <= rslot_r;
          fkind_r <= rk_r;
        end
        S_SCAN, S_LAST: if (idx_r != '0 && !found_r) begin
          if (cmd_r.mode == art_pkg::MODE_REPORT) begin
            if (rv_r) begin
              if (cnt_r != art_pkg::COUNT_MAX) cnt_r <= cnt_r + 13'd1;
              sum_r <= sum_add[48] ? art_pkg::BYTES_MAX : sum_add[47:0];
            end
          end else if (hit) begin
            found_r <= 1'b1;
            fslot_r <= rslot_r;
            fkind_r <= rk_r;
          end
        end
        S_DONE: begin
          out_tvalid <= 1'b1;
          out_status <= art_pkg::ST_OK;
          out_slot <= '0;
          out_seq <= '0;
          out_brk <= 1'b0;
          out_count <= '0;
          out_bytes <= '0;
          if (cmd_r.null_addr) out_status <= art_pkg::ST_NULL;
          else if (cmd_r.mode == art_pkg::MODE_REPORT) begin
            out_count <= cnt_r;
            out_bytes <= sum_r;
          end else if (!found_r) begin
            out_status <= (cmd_r.mode == art_pkg::MODE_RECORD) ? art_pkg::ST_FULL
                                                              : art_pkg::ST_NOTFOUND;
          end else begin
            out_slot <= 12'(fslot_r);
            if (cmd_r.mode == art_pkg::MODE_RECORD) begin
              ctr_r <= seq_new;
              out_seq <= seq_new;
              out_brk <= (break_seq != 64'd0 && seq_new == break_seq) ||
                         (break_addr != 32'd0 && cmd_r.addr == break_addr);
            end else if (fkind_r != cmd_r.kind) out_status <= art_pkg::ST_KIND;
          end
        end
        S_OUT: if (out_tready) out_tvalid <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

### rtl/allocation_record_table.sv
// Top level of the allocation record table: config registers, front end, back end.
// Depends on art_pkg, art_front, art_back.
// Item path: front-end queue, then the back end probes the home slot, scans the table on a
// miss, and registers the result; a null address skips the probe, a report walks the table.
// The back end takes one item at a time and holds each result until out_tready;
// the slot memory port and scan set the rate.
// Reset: synchronous active low; a clearing pass over all TABLE_ENTRIES slots follows reset.
`timescale 1ns / 1ps
module allocation_record_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [71:0]   in_tdata,   // mode[1:0], block_address[33:2], block_bytes[65:34],
                                    // alloc_kind[67:66], zero fill
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,  // status[2:0], slot_index[14:3], sequence_number[78:15],
                                    // break_hit[79], live_count[92:80], live_bytes[140:93]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_data
);
  logic [63:0]   brk_seq_r;
  logic [31:0]   brk_addr_r;
  logic          q_valid, q_ready;
  art_pkg::cmd_t q_cmd;
  logic [2:0]    o_status;
  logic [11:0]   o_slot;
  logic [63:0]   o_seq;
  logic          o_brk;
  logic [12:0]   o_count;
  logic [47:0]   o_bytes;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_seq_r <= '0;
      brk_addr_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        art_pkg::CFG_BREAK_SEQ: brk_seq_r <= cfg_data;
        art_pkg::CFG_BREAK_ADDR: brk_addr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  art_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_mode(in_tdata[1:0]), .in_addr(in_tdata[33:2]),
    .in_bytes(in_tdata[65:34]), .in_kind(in_tdata[67:66]),
    .q_valid, .q_ready, .q_cmd
  );

  art_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .break_seq(brk_seq_r), .break_addr(brk_addr_r),
    .out_tvalid, .out_tready,
    .out_status(o_status), .out_slot(o_slot), .out_seq(o_seq),
    .out_brk(o_brk), .out_count(o_count), .out_bytes(o_bytes)
  );

  assign out_tdata = {3'd0, o_bytes, o_count, o_brk, o_seq, o_slot, o_status};
endmodule

### tb/sv/allocation_record_table_test.sv
// Self-checking test of allocation_record_table: directed rows and random traffic.
// Each item and each register write is mirrored in a local table model.
// Depends on art_pkg and the allocation_record_table RTL.
`timescale 1ns / 1ps
module allocation_record_table_test;
  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [63:0] seq;
    logic        brk;
    logic [12:0] cnt;
    logic [47:0] sum;
  } res_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [31:0] bytes;
    logic [1:0]  kind;
    bit          typed;
    res_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  allocation_record_table DUT (.*);

  always #6 clk = ~clk;

  // table model
  bit          tab_valid [art_pkg::TABLE_ENTRIES];
  logic [31:0] tab_addr [art_pkg::TABLE_ENTRIES];
  logic [31:0] tab_bytes [art_pkg::TABLE_ENTRIES];
  logic [1:0]  tab_kind [art_pkg::TABLE_ENTRIES];
  logic [63:0] seq_count = '0;
  logic [63:0] brk_seq = '0;
  logic [31:0] brk_addr = '0;
  logic [31:0] live_q [$];

  res_t pending_q [$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  bit no_idle = 1'b0;
  bit hold_go = 1'b0;
  int held = 0;

  function automatic int free_slot(logic [31:0] a);
    if (!tab_valid[a[11:0]]) return a[11:0];
    for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++) if (!tab_valid[i]) return i;
    return -1;
  endfunction

  function automatic int live_slot(logic [31:0] a);
    if (tab_valid[a[11:0]] && tab_addr[a[11:0]] == a) return a[11:0];
    for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++)
      if (tab_valid[i] && tab_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic res_t table_update(logic [1:0] mode, logic [31:0] a, logic [31:0] b,
                                        logic [1:0] k);
    res_t r;
    int s;
    logic [48:0] acc;
    r = '0;
    acc = '0;
    if (mode == art_pkg::MODE_REPORT) begin
      for (int i = 0; i < art_pkg::TABLE_ENTRIES; i++) if (tab_valid[i]) begin
        if (r.cnt != art_pkg::COUNT_MAX) r.cnt++;
        acc = acc + tab_bytes[i];
        if (acc > art_pkg::BYTES_MAX) acc = art_pkg::BYTES_MAX;
      end
      r.sum = acc[47:0];
    end else if (a == 0) begin
      r.status = art_pkg::ST_NULL;
    end else if (mode == art_pkg::MODE_RECORD) begin
      s = free_slot(a);
      if (s < 0) r.status = art_pkg::ST_FULL;
      else begin
        tab_valid[s] = 1'b1;
        tab_addr[s] = a;
        tab_bytes[s] = b;
        tab_kind[s] = k;
        seq_count++;
        r.seq = seq_count;
        r.slot = 12'(s);
        r.brk = (brk_seq != 0 && seq_count == brk_seq) || (brk_addr != 0 && a == brk_addr);
        live_q.push_back(a);
      end
    end else begin
      s = live_slot(a);
      if (s < 0) r.status = art_pkg::ST_NOTFOUND;
      else begin
        r.slot = 12'(s);
        if (tab_kind[s] != k) r.status = art_pkg::ST_KIND;
        if (mode == art_pkg::MODE_RELEASE) begin
          tab_valid[s] = 1'b0;
          foreach (live_q[i]) if (live_q[i] == a) begin
            live_q.delete(i);
            break;
          end
        end else if (tab_kind[s] == k) tab_bytes[s] = b;
      end
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] mode, logic [31:0] a, logic [31:0] b, logic [1:0] k,
                           bit typed = 0, res_t tres = '0);
    res_t r;
    in_tdata <= {4'b0, k, b, a, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = table_update(mode, a, b, k);
    pending_q.push_back(typed ? tres : r);
    if (no_idle) return;
    if (burst_left > 0) burst_left--;
    else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == art_pkg::CFG_BREAK_SEQ) brk_seq = val;
    else brk_addr = val[31:0];
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_go && held < 3000) begin
      held <= held + 1;
      out_tready <= 1'b0;
    end else begin
      case ((cycles / 500) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (out_tvalid && out_tready) begin
      got.status = out_tdata[2:0];
      got.slot = out_tdata[14:3];
      got.seq = out_tdata[78:15];
      got.brk = out_tdata[79];
      got.cnt = out_tdata[92:80];
      got.sum = out_tdata[140:93];
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch exp st=%0d sl=%0d sq=%0d bk=%0d cn=%0d by=%0d ",
                      "got st=%0d sl=%0d sq=%0d bk=%0d cn=%0d by=%0d"},
                     want.status, want.slot, want.seq, want.brk, want.cnt, want.sum,
                     got.status, got.slot, got.seq, got.brk, got.cnt, got.sum);
        end
      end
    end
  end

  row_t rows [] = '{
    '{art_pkg::MODE_REPORT, 32'h0, 32'h0, 2'd0, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RECORD, 32'h0, 32'h5, 2'd0, 1,
      '{art_pkg::ST_NULL, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RELEASE, 32'h0, 32'h0, 2'd1, 1,
      '{art_pkg::ST_NULL, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RESIZE, 32'h0, 32'h9, 2'd2, 1,
      '{art_pkg::ST_NULL, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RECORD, 32'h1005, 32'd100, 2'd0, 1,
      '{art_pkg::ST_OK, 12'd5, 64'd1, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1,
      '{art_pkg::ST_OK, 12'hFFF, 64'd2, 1'b1, 13'd0, 48'd0}},
    '{art_pkg::MODE_RECORD, 32'h2005, 32'd7, 2'd1, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd3, 1'b1, 13'd0, 48'd0}},
    '{art_pkg::MODE_REPORT, 32'h0, 32'h0, 2'd0, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd3, 48'h1_0000_006A}},
    '{art_pkg::MODE_RESIZE, 32'h2005, 32'd50, 2'd0, 1,
      '{art_pkg::ST_KIND, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RESIZE, 32'h2005, 32'd50, 2'd1, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RELEASE, 32'h1005, 32'h0, 2'd2, 1,
      '{art_pkg::ST_KIND, 12'd5, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RELEASE, 32'h1005, 32'h0, 2'd0, 1,
      '{art_pkg::ST_NOTFOUND, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RESIZE, 32'h3333, 32'h1, 2'd0, 1,
      '{art_pkg::ST_NOTFOUND, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd2, 48'h1_0000_0031}},
    '{art_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 32'h0, 2'd3, 1,
      '{art_pkg::ST_OK, 12'hFFF, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RELEASE, 32'h2005, 32'h0, 2'd1, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_REPORT, 32'h0, 32'h0, 2'd0, 1,
      '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0}},
    '{art_pkg::MODE_RECORD, 32'h8000_0000, 32'd1, 2'd2, 0, '0},
    '{art_pkg::MODE_RESIZE, 32'h8000_0000, 32'h8000_0000, 2'd2, 0, '0}
  };

  initial begin
    int pick, s;
    logic [31:0] a;
    logic [1:0] k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(art_pkg::CFG_BREAK_SEQ, 64'd3);
    write_reg(art_pkg::CFG_BREAK_ADDR, 32'hFFFF_FFFF);
    foreach (rows[i]) send_item(rows[i].mode, rows[i].addr, rows[i].bytes, rows[i].kind,
                                rows[i].typed, rows[i].res);
    for (int n = 0; n < 1950; n++) begin
      if (n % 400 == 399) begin
        case (n / 400)
          0: begin
            write_reg(art_pkg::CFG_BREAK_SEQ, 64'd0);
            write_reg(art_pkg::CFG_BREAK_ADDR, 32'd0);
          end
          1: begin
            write_reg(art_pkg::CFG_BREAK_SEQ, '1);
            write_reg(art_pkg::CFG_BREAK_ADDR, $urandom);
          end
          2: begin
            write_reg(art_pkg::CFG_BREAK_SEQ, seq_count + $urandom_range(1, 6));
            write_reg(art_pkg::CFG_BREAK_ADDR, live_q.size() ? live_q[0] : 32'h1);
          end
          default: write_reg(art_pkg::CFG_BREAK_SEQ, {$urandom, $urandom});
        endcase
      end
      if (n == 1000) hold_go = 1'b1;
      no_idle = (n % 300) < 60;
      pick = $urandom_range(0, 99);
      if (pick < 2)
        send_item(2'($urandom_range(0, 2)), 32'h0, $urandom, 2'($urandom_range(0, 3)));
      else if (pick < 3)
        send_item(art_pkg::MODE_REPORT, $urandom, $urandom, 2'($urandom_range(0, 3)));
      else if (pick < 6)
        send_item(2'($urandom_range(1, 2)), $urandom, $urandom, 2'($urandom_range(0, 3)));
      else if (pick < 55 && live_q.size() < 64 || live_q.size() == 0) begin
        a = $urandom;
        if ($urandom_range(0, 99) >= 3)
          for (int t = 0; t < 6 && (tab_valid[a[11:0]] || a == 0); t++) a = $urandom;
        send_item(art_pkg::MODE_RECORD, a, $urandom, 2'($urandom_range(0, 3)));
      end else begin
        a = live_q[$urandom_range(0, live_q.size() - 1)];
        s = live_slot(a);
        k = ($urandom_range(0, 9) < 8) ? tab_kind[s] : 2'($urandom);
        send_item($urandom_range(0, 1) ? art_pkg::MODE_RELEASE : art_pkg::MODE_RESIZE,
                  a, $urandom, k);
      end
    end
    drain();
    while (live_q.size() != 0)
      send_item(art_pkg::MODE_RELEASE, live_q[0], 32'd0, tab_kind[live_slot(live_q[0])]);
    send_item(art_pkg::MODE_REPORT, 32'd0, 32'd0, 2'd0, 1,
              '{art_pkg::ST_OK, 12'd0, 64'd0, 1'b0, 13'd0, 48'd0});
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
